@@ src/tsr_pkg.sv @@
// Shared types for the triangle span rasterizer.
// Holds the controller states, edge selects and the command/status structs.
// No dependencies.
package tsr_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DSTART,
    S_DWAIT,
    S_INIT,
    S_EMIT
  } state_e;

  typedef enum logic [1:0] {
    EDGE_LONG,
    EDGE_UPPER,
    EDGE_LOWER
  } edge_e;

  typedef struct packed {
    logic  load;
    logic  div_start;
    logic  div_store;
    edge_e div_sel;
    logic  walk_init;
    logic  emit;
  } cmd_t;

  typedef struct packed {
    logic flat;
    logic div_done;
    logic out_free;
    logic last_row;
  } sts_t;

endpackage

@@ src/tsr_div.sv @@
// Restoring divider, one quotient bit per cycle, for edge slopes.
// Depends on nothing; instanced by tsr_dpath.
module tsr_div #(
  parameter int NUM_W = 26,
  parameter int DEN_W = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_q, rem_d, den_q;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [DEN_W:0]   shifted, diff;
  logic             ge;

  assign shifted = {rem_q, quo_q[NUM_W-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

@@ src/tsr_dpath.sv @@
// Datapath: vertex sort, slope registers, edge walkers and span output register.
// Depends on tsr_pkg and tsr_div; driven by tsr_ctrl commands.
module tsr_dpath #(
  parameter int ROW_BITS        = 6,
  parameter int COL_BITS        = 10,
  parameter int SLOPE_FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tsr_pkg::cmd_t       cmd_i,
  output tsr_pkg::sts_t       sts_o,
  input  logic [COL_BITS-1:0] vertex_a_x_i,
  input  logic [ROW_BITS-1:0] vertex_a_y_i,
  input  logic [COL_BITS-1:0] vertex_b_x_i,
  input  logic [ROW_BITS-1:0] vertex_b_y_i,
  input  logic [COL_BITS-1:0] vertex_c_x_i,
  input  logic [ROW_BITS-1:0] vertex_c_y_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ROW_BITS-1:0] span_row_o,
  output logic [COL_BITS-1:0] span_start_o,
  output logic [COL_BITS-1:0] span_end_o,
  output logic                last_span_o
);

  import tsr_pkg::*;

  localparam int F  = SLOPE_FRAC_BITS;
  localparam int QW = COL_BITS + F;
  localparam int SW = QW + 1;
  localparam int XW = QW + 2;

  function automatic logic [COL_BITS-1:0] round_x(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] r;
    logic [XW-F-1:0]      u;
    r = v + $signed({{(XW-F){1'b0}}, 1'b1, {(F-1){1'b0}}});
    u = r[XW-1:F];
    if (r[XW-1]) begin
      return '0;
    end else if (u[XW-F-1:COL_BITS] != '0) begin
      return '1;
    end else begin
      return u[COL_BITS-1:0];
    end
  endfunction

  logic [COL_BITS-1:0] xlo_q, xmid_q, xhi_q, sxl, sxm, sxh;
  logic [ROW_BITS-1:0] ylo_q, ymid_q, yhi_q, syl, sym, syh;
  logic [COL_BITS-1:0] ax, bx;
  logic [ROW_BITS-1:0] dy;
  logic [COL_BITS:0]   dx, dmag;
  logic                neg;
  logic [QW-1:0]       quo;
  logic                div_done;
  logic signed [SW-1:0] slope, d1_q, d2a_q, d2b_q, d2;
  logic signed [XW-1:0] x1_q, x2_q, xmin, xmax, xlo_fx, xmid_fx;
  logic [ROW_BITS-1:0]  row_q;
  logic                 out_valid_q;
  logic [ROW_BITS-1:0]  span_row_q;
  logic [COL_BITS-1:0]  span_start_q, span_end_q;
  logic                 last_span_q;

  always_comb begin
    if (vertex_a_y_i <= vertex_b_y_i && vertex_a_y_i <= vertex_c_y_i) begin
      sxl = vertex_a_x_i;
      syl = vertex_a_y_i;
      if (vertex_b_y_i <= vertex_c_y_i) begin
        sxm = vertex_b_x_i; sym = vertex_b_y_i; sxh = vertex_c_x_i; syh = vertex_c_y_i;
      end else begin
        sxm = vertex_c_x_i; sym = vertex_c_y_i; sxh = vertex_b_x_i; syh = vertex_b_y_i;
      end
    end else if (vertex_b_y_i <= vertex_a_y_i && vertex_b_y_i <= vertex_c_y_i) begin
      sxl = vertex_b_x_i;
      syl = vertex_b_y_i;
      if (vertex_a_y_i <= vertex_c_y_i) begin
        sxm = vertex_a_x_i; sym = vertex_a_y_i; sxh = vertex_c_x_i; syh = vertex_c_y_i;
      end else begin
        sxm = vertex_c_x_i; sym = vertex_c_y_i; sxh = vertex_a_x_i; syh = vertex_a_y_i;
      end
    end else begin
      sxl = vertex_c_x_i;
      syl = vertex_c_y_i;
      if (vertex_a_y_i <= vertex_b_y_i) begin
        sxm = vertex_a_x_i; sym = vertex_a_y_i; sxh = vertex_b_x_i; syh = vertex_b_y_i;
      end else begin
        sxm = vertex_b_x_i; sym = vertex_b_y_i; sxh = vertex_a_x_i; syh = vertex_a_y_i;
      end
    end
  end

  always_comb begin
    case (cmd_i.div_sel)
      EDGE_LONG: begin
        ax = xhi_q;  bx = xlo_q;  dy = yhi_q - ylo_q;
      end
      EDGE_UPPER: begin
        ax = xmid_q; bx = xlo_q;  dy = ymid_q - ylo_q;
      end
      EDGE_LOWER: begin
        ax = xhi_q;  bx = xmid_q; dy = yhi_q - ymid_q;
      end
      default: begin
        ax = xhi_q;  bx = xlo_q;  dy = yhi_q - ylo_q;
      end
    endcase
  end

  assign dx   = {1'b0, ax} - {1'b0, bx};
  assign neg  = dx[COL_BITS];
  assign dmag = neg ? -dx : dx;

  tsr_div #(
    .NUM_W(QW),
    .DEN_W(ROW_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  ({dmag[COL_BITS-1:0], {F{1'b0}}}),
    .den_i  (dy),
    .done_o (div_done),
    .quo_o  (quo)
  );

  always_comb begin
    if (dy == '0) begin
      slope = '0;
    end else if (neg) begin
      slope = -$signed({1'b0, quo});
    end else begin
      slope = $signed({1'b0, quo});
    end
  end

  assign xlo_fx  = $signed({2'b00, xlo_q, {F{1'b0}}});
  assign xmid_fx = $signed({2'b00, xmid_q, {F{1'b0}}});
  assign xmin    = (x1_q < x2_q) ? x1_q : x2_q;
  assign xmax    = (x1_q < x2_q) ? x2_q : x1_q;
  assign d2      = (row_q < ymid_q) ? d2a_q : d2b_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      xlo_q  <= sxl;
      xmid_q <= sxm;
      xhi_q  <= sxh;
      ylo_q  <= syl;
      ymid_q <= sym;
      yhi_q  <= syh;
    end
    if (cmd_i.div_store) begin
      case (cmd_i.div_sel)
        EDGE_LONG:  d1_q  <= slope;
        EDGE_UPPER: d2a_q <= slope;
        EDGE_LOWER: d2b_q <= slope;
        default:    d1_q  <= slope;
      endcase
    end
    if (cmd_i.walk_init) begin
      row_q <= ylo_q;
      x1_q  <= xlo_fx;
      x2_q  <= (ymid_q == ylo_q) ? xmid_fx : xlo_fx;
    end else if (cmd_i.emit) begin
      row_q <= row_q + 1'b1;
      x1_q  <= x1_q + {{(XW-SW){d1_q[SW-1]}}, d1_q};
      x2_q  <= x2_q + {{(XW-SW){d2[SW-1]}}, d2};
    end
    if (cmd_i.emit) begin
      span_row_q   <= row_q;
      span_start_q <= round_x(xmin);
      span_end_q   <= round_x(xmax);
      last_span_q  <= (row_q == yhi_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.flat     = (ylo_q == yhi_q);
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.last_row = (row_q == yhi_q);

  assign out_valid_o  = out_valid_q;
  assign span_row_o   = span_row_q;
  assign span_start_o = span_start_q;
  assign span_end_o   = span_end_q;
  assign last_span_o  = last_span_q;

endmodule

@@ src/tsr_ctrl.sv @@
// Controller state machine: sequences load, three slope divisions and span emission.
// Depends on tsr_pkg; drives tsr_dpath through command and status structs.
module tsr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tsr_pkg::sts_t sts_i,
  output tsr_pkg::cmd_t cmd_o
);

  import tsr_pkg::*;

  state_e state_q, state_d;
  edge_e  edge_q, edge_d;

  always_comb begin
    state_d = state_q;
    edge_d  = edge_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        edge_d  = EDGE_LONG;
        state_d = sts_i.flat ? S_IDLE : S_DSTART;
      end
      S_DSTART: begin
        state_d = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts_i.div_done) begin
          unique case (edge_q)
            EDGE_LONG: begin
              edge_d  = EDGE_UPPER;
              state_d = S_DSTART;
            end
            EDGE_UPPER: begin
              edge_d  = EDGE_LOWER;
              state_d = S_DSTART;
            end
            default: begin
              state_d = S_INIT;
            end
          endcase
        end
      end
      S_INIT: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free && sts_i.last_row) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.div_sel = edge_q;
    in_ready_o    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_DSTART: cmd_o.div_start = 1'b1;
      S_DWAIT:  cmd_o.div_store = sts_i.div_done;
      S_INIT:   cmd_o.walk_init = 1'b1;
      S_EMIT:   cmd_o.emit      = sts_i.out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      edge_q  <= EDGE_LONG;
    end else begin
      state_q <= state_d;
      edge_q  <= edge_d;
    end
  end

endmodule

@@ src/triangle_span_rasterizer.sv @@
// Triangle span rasterizer top level: controller plus datapath.
// Depends on tsr_pkg, tsr_ctrl, tsr_dpath (and tsr_div below it).
//
//   channel  direction  handshake                fields
//   vertex   in         in_valid_i / in_ready_o   vertex_{a,b,c}_{x,y}_i
//   span     out        out_valid_o / out_ready_i span_row_o span_start_o span_end_o
//                                                 last_span_o
//
// One triangle at a time: load and check, then three slope divisions on one
// shared bit-serial divider of COL_BITS+SLOPE_FRAC_BITS quotient bits, then
// start the walkers, then one span beat per cycle while out_ready_i allows.
// Flat triangles return to idle with no beat.
// Reset clears the controller and output valid; a stalled span beat holds
// the walkers, and the next triangle is taken while the last beat waits.
module triangle_span_rasterizer #(
  parameter int ROW_BITS        = 6,
  parameter int COL_BITS        = 10,
  parameter int SLOPE_FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [COL_BITS-1:0] vertex_a_x_i,
  input  logic [ROW_BITS-1:0] vertex_a_y_i,
  input  logic [COL_BITS-1:0] vertex_b_x_i,
  input  logic [ROW_BITS-1:0] vertex_b_y_i,
  input  logic [COL_BITS-1:0] vertex_c_x_i,
  input  logic [ROW_BITS-1:0] vertex_c_y_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ROW_BITS-1:0] span_row_o,
  output logic [COL_BITS-1:0] span_start_o,
  output logic [COL_BITS-1:0] span_end_o,
  output logic                last_span_o
);

  import tsr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tsr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  tsr_dpath #(
    .ROW_BITS       (ROW_BITS),
    .COL_BITS       (COL_BITS),
    .SLOPE_FRAC_BITS(SLOPE_FRAC_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .vertex_a_x_i(vertex_a_x_i),
    .vertex_a_y_i(vertex_a_y_i),
    .vertex_b_x_i(vertex_b_x_i),
    .vertex_b_y_i(vertex_b_y_i),
    .vertex_c_x_i(vertex_c_x_i),
    .vertex_c_y_i(vertex_c_y_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .span_row_o  (span_row_o),
    .span_start_o(span_start_o),
    .span_end_o  (span_end_o),
    .last_span_o (last_span_o)
  );

endmodule
